[rtl/core/c8ie_pkg.sv]
// Shared types, opcodes and constants for the CHIP-8 instruction execute block.
package c8ie_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpW        = $clog2(StackDepth);

  typedef logic [SpW-1:0] sp_t;

  localparam sp_t        SpLast  = sp_t'(StackDepth - 1);
  localparam logic [11:0] PcReset = 12'h200;
  localparam logic [3:0]  RegFlag = 4'hF;

  localparam logic [3:0] OpSys   = 4'h0;
  localparam logic [3:0] OpJump  = 4'h1;
  localparam logic [3:0] OpCall  = 4'h2;
  localparam logic [3:0] OpSeImm = 4'h3;
  localparam logic [3:0] OpSnImm = 4'h4;
  localparam logic [3:0] OpSeReg = 4'h5;
  localparam logic [3:0] OpLdImm = 4'h6;
  localparam logic [3:0] OpAdImm = 4'h7;
  localparam logic [3:0] OpAlu   = 4'h8;

  localparam logic [11:0] SysCls = 12'h0E0;
  localparam logic [11:0] SysRet = 12'h0EE;

  localparam logic [3:0] AluMov = 4'h0;
  localparam logic [3:0] AluOr  = 4'h1;
  localparam logic [3:0] AluAnd = 4'h2;
  localparam logic [3:0] AluXor = 4'h3;
  localparam logic [3:0] AluAdd = 4'h4;
  localparam logic [3:0] AluSub = 4'h5;
  localparam logic [3:0] AluShr = 4'h6;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [7:0]  reg_value;
    logic        flag_written;
    logic        flag_value;
    logic        clear_screen;
    logic        unsupported;
  } res_t;

  typedef struct packed {
    logic push;
    sp_t  sp_next;
  } upd_t;

endpackage

[rtl/core/c8ie_if.sv]
// Valid/ready channel interfaces for instruction items and result items.
interface c8ie_ins_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;

  modport source(output valid, output instruction, input ready);
  modport sink(input valid, input instruction, output ready);
endinterface

interface c8ie_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic        reg_written;
  logic [3:0]  reg_index;
  logic [7:0]  reg_value;
  logic        flag_written;
  logic        flag_value;
  logic        clear_screen;
  logic        unsupported;

  modport source(output valid, output next_pc, output reg_written, output reg_index,
                 output reg_value, output flag_written, output flag_value,
                 output clear_screen, output unsupported, input ready);
  modport sink(input valid, input next_pc, input reg_written, input reg_index,
               input reg_value, input flag_written, input flag_value,
               input clear_screen, input unsupported, output ready);
endinterface

[rtl/core/c8ie_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module c8ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/c8ie_exec.sv]
// Instruction decode and ALU: computes the result and state update of one instruction.
module c8ie_exec (
  input  logic [15:0]          ins_i,
  input  logic [7:0]           vx_i,
  input  logic [7:0]           vy_i,
  input  logic [11:0]          pc_i,
  input  logic [11:0]          ret_pc_i,
  input  c8ie_pkg::sp_t        sp_i,
  output c8ie_pkg::res_t       res_o,
  output c8ie_pkg::upd_t       upd_o
);

  logic [3:0]  op;
  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [8:0]  sum;
  logic [11:0] pc_skip;

  assign op      = ins_i[15:12];
  assign x       = ins_i[11:8];
  assign n       = ins_i[3:0];
  assign kk      = ins_i[7:0];
  assign nnn     = ins_i[11:0];
  assign sum     = {1'b0, vx_i} + {1'b0, vy_i};
  assign pc_skip = pc_i + 12'd2;

  always_comb begin
    res_o         = '0;
    res_o.next_pc = pc_i;
    upd_o.push    = 1'b0;
    upd_o.sp_next = sp_i;

    case (op)
      c8ie_pkg::OpSys: begin
        if (nnn == c8ie_pkg::SysCls) begin
          res_o.clear_screen = 1'b1;
        end else if (nnn == c8ie_pkg::SysRet) begin
          upd_o.sp_next = (sp_i == '0) ? c8ie_pkg::SpLast : sp_i - 1'b1;
          res_o.next_pc = ret_pc_i;
        end else begin
          res_o.unsupported = 1'b1;
        end
      end
      c8ie_pkg::OpJump: begin
        res_o.next_pc = nnn;
      end
      c8ie_pkg::OpCall: begin
        upd_o.push    = 1'b1;
        upd_o.sp_next = (sp_i == c8ie_pkg::SpLast) ? '0 : sp_i + 1'b1;
        res_o.next_pc = nnn;
      end
      c8ie_pkg::OpSeImm: begin
        if (vx_i == kk) res_o.next_pc = pc_skip;
      end
      c8ie_pkg::OpSnImm: begin
        if (vx_i != kk) res_o.next_pc = pc_skip;
      end
      c8ie_pkg::OpSeReg: begin
        if (vx_i == vy_i) res_o.next_pc = pc_skip;
      end
      c8ie_pkg::OpLdImm: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = kk;
      end
      c8ie_pkg::OpAdImm: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = vx_i + kk;
      end
      c8ie_pkg::OpAlu: begin
        res_o.reg_written = 1'b1;
        case (n)
          c8ie_pkg::AluMov: res_o.reg_value = vy_i;
          c8ie_pkg::AluOr:  res_o.reg_value = vx_i | vy_i;
          c8ie_pkg::AluAnd: res_o.reg_value = vx_i & vy_i;
          c8ie_pkg::AluXor: res_o.reg_value = vx_i ^ vy_i;
          c8ie_pkg::AluAdd: begin
            res_o.reg_value    = sum[7:0];
            res_o.flag_written = 1'b1;
            res_o.flag_value   = sum[8];
          end
          c8ie_pkg::AluSub: begin
            res_o.reg_value    = vx_i - vy_i;
            res_o.flag_written = 1'b1;
            res_o.flag_value   = (vx_i >= vy_i);
          end
          c8ie_pkg::AluShr: begin
            res_o.reg_value    = {1'b0, vx_i[7:1]};
            res_o.flag_written = 1'b1;
            res_o.flag_value   = vx_i[0];
          end
          default: begin
            res_o.reg_written = 1'b0;
            res_o.unsupported = 1'b1;
          end
        endcase
      end
      default: begin
        res_o.unsupported = 1'b1;
      end
    endcase

    res_o.reg_index = res_o.reg_written ? x : 4'h0;
  end

endmodule

[rtl/core/chip8_instruction_execute.sv]
// Top level of the CHIP-8 instruction execute block.
//
// Usage: instruction words arrive as items on ins_i and results leave on res_o,
// both valid/ready channels. An item is taken into an input register; from
// there it is decoded and executed against the data registers, the
// program counter and the return stack, and its result is loaded into the
// output register when it is free. One item per cycle is sustained while the
// receiver takes every result. The register file and the return stack are
// RAMs with registered reads, addressed as the item is accepted; a write by the
// item executing in that same cycle is forwarded. Register 15 lives in a flop.
// A stalled receiver holds the result in the output register; the input
// register still fills, and ins_i.ready drops only when both stages are full.
// Reset empties both stages, clears data registers 0 to 14 to zero through
// per-entry valid bits and register 15 in its flop, sets the program counter
// to 0x200 and the stack pointer to zero. The return stack is not cleared;
// returning to an entry never pushed gives an undefined program counter.
module chip8_instruction_execute (
  input  logic              clk_i,
  input  logic              rst_ni,
  c8ie_ins_if.sink          ins_i,
  c8ie_res_if.source        res_o
);

  logic                s1_valid_q;
  logic [15:0]         ins_q;
  logic                out_valid_q;
  c8ie_pkg::res_t      out_q;
  logic [11:0]         pc_q;
  c8ie_pkg::sp_t       sp_q;
  logic [7:0]          v15_q;
  logic [15:0]         rf_valid_q;

  logic                fwd_x_q;
  logic                fwd_y_q;
  logic                valid_x_q;
  logic                valid_y_q;
  logic [7:0]          rf_wdata_q;
  logic                st_fwd_q;
  logic [11:0]         st_wdata_q;

  logic                advance;
  logic                accept;
  logic [3:0]          raddr_x;
  logic [3:0]          raddr_y;
  logic [7:0]          rdata_x;
  logic [7:0]          rdata_y;
  logic [7:0]          vx;
  logic [7:0]          vy;
  logic                rf_we;
  logic [11:0]         ret_pc;
  logic [11:0]         st_rdata;
  logic                st_we;
  c8ie_pkg::sp_t       sp_eff;
  c8ie_pkg::sp_t       st_raddr;
  c8ie_pkg::res_t      res;
  c8ie_pkg::upd_t      upd;

  assign advance     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign ins_i.ready = !s1_valid_q || advance;
  assign accept      = ins_i.valid && ins_i.ready;

  assign raddr_x = ins_i.instruction[11:8];
  assign raddr_y = ins_i.instruction[7:4];

  assign rf_we = advance && res.reg_written && (ins_q[11:8] != c8ie_pkg::RegFlag);

  c8ie_ram #(.Width(8), .Depth(16)) u_rf_x (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (ins_q[11:8]),
    .wdata_i (res.reg_value),
    .re_i    (accept),
    .raddr_i (raddr_x),
    .rdata_o (rdata_x)
  );

  c8ie_ram #(.Width(8), .Depth(16)) u_rf_y (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (ins_q[11:8]),
    .wdata_i (res.reg_value),
    .re_i    (accept),
    .raddr_i (raddr_y),
    .rdata_o (rdata_y)
  );

  assign sp_eff   = advance ? upd.sp_next : sp_q;
  assign st_raddr = (sp_eff == '0) ? c8ie_pkg::SpLast : sp_eff - 1'b1;
  assign st_we    = advance && upd.push;

  c8ie_ram #(.Width(12), .Depth(c8ie_pkg::StackDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (sp_q),
    .wdata_i (pc_q),
    .re_i    (accept),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  always_comb begin
    if (ins_q[11:8] == c8ie_pkg::RegFlag) begin
      vx = v15_q;
    end else if (fwd_x_q) begin
      vx = rf_wdata_q;
    end else begin
      vx = valid_x_q ? rdata_x : 8'h00;
    end
    if (ins_q[7:4] == c8ie_pkg::RegFlag) begin
      vy = v15_q;
    end else if (fwd_y_q) begin
      vy = rf_wdata_q;
    end else begin
      vy = valid_y_q ? rdata_y : 8'h00;
    end
  end

  assign ret_pc = st_fwd_q ? st_wdata_q : st_rdata;

  c8ie_exec u_exec (
    .ins_i    (ins_q),
    .vx_i     (vx),
    .vy_i     (vy),
    .pc_i     (pc_q),
    .ret_pc_i (ret_pc),
    .sp_i     (sp_q),
    .res_o    (res),
    .upd_o    (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= c8ie_pkg::PcReset;
      sp_q        <= '0;
      v15_q       <= 8'h00;
      rf_valid_q  <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        pc_q <= res.next_pc;
        sp_q <= upd.sp_next;
        if (res.flag_written) begin
          v15_q <= {7'b0, res.flag_value};
        end else if (res.reg_written && ins_q[11:8] == c8ie_pkg::RegFlag) begin
          v15_q <= res.reg_value;
        end
      end
      if (rf_we) begin
        rf_valid_q[ins_q[11:8]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q      <= ins_i.instruction;
      fwd_x_q    <= rf_we && (ins_q[11:8] == raddr_x);
      fwd_y_q    <= rf_we && (ins_q[11:8] == raddr_y);
      valid_x_q  <= rf_valid_q[raddr_x];
      valid_y_q  <= rf_valid_q[raddr_y];
      rf_wdata_q <= res.reg_value;
      st_fwd_q   <= st_we && (sp_q == st_raddr);
      st_wdata_q <= pc_q;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.next_pc      = out_q.next_pc;
  assign res_o.reg_written  = out_q.reg_written;
  assign res_o.reg_index    = out_q.reg_index;
  assign res_o.reg_value    = out_q.reg_value;
  assign res_o.flag_written = out_q.flag_written;
  assign res_o.flag_value   = out_q.flag_value;
  assign res_o.clear_screen = out_q.clear_screen;
  assign res_o.unsupported  = out_q.unsupported;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(ins_q))
    else $error("Input register changed while its item was stalled.");

  a_flag_to_v15: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.flag_written |=> v15_q == {7'b0, $past(res.flag_value)})
    else $error("Register 15 does not hold the flag just written.");

  a_push_moves_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && upd.push |=> sp_q != $past(sp_q))
    else $error("Stack pointer did not move on a call.");

  a_unsup_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.unsupported |-> !res_o.reg_written && !res_o.flag_written)
    else $error("Unsupported instruction wrote a register.");

  a_flag_implies_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.flag_written |-> res_o.reg_written)
    else $error("Flag written without a register result.");

endmodule

[test/c8ie_exec_tracker_pkg.sv]
// Scoreboard class that predicts and checks result items of the CHIP-8 execute block.
package c8ie_exec_tracker_pkg;
  import c8ie_pkg::*;

  localparam int unsigned MaxReports = 10;

  class chip8_exec_tracker;
    logic [7:0]  vreg [16];
    logic [11:0] pc;
    logic [11:0] ret_stack [StackDepth];
    bit          stack_written [StackDepth];
    sp_t         sp;
    res_t        pending_results [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      foreach (vreg[i]) vreg[i] = 8'h00;
      foreach (stack_written[i]) stack_written[i] = 1'b0;
      pc = PcReset;
      sp = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    // A return is only legal when the entry it pops has been pushed at some point.
    function bit can_return();
      return stack_written[(sp == '0) ? SpLast : sp - 1'b1];
    endfunction

    function string describe(res_t r);
      return $sformatf("pc=%h rw=%b idx=%h val=%h fw=%b fv=%b cls=%b uns=%b", r.next_pc,
                       r.reg_written, r.reg_index, r.reg_value, r.flag_written,
                       r.flag_value, r.clear_screen, r.unsupported);
    endfunction

    function void note_instruction(logic [15:0] word);
      logic [3:0]  op, x, y, n;
      logic [11:0] nnn, npc;
      logic [7:0]  kk, vx, vy;
      logic [8:0]  wide;
      res_t        want;
      op = word[15:12];
      x = word[11:8];
      y = word[7:4];
      n = word[3:0];
      nnn = word[11:0];
      kk = word[7:0];
      vx = vreg[x];
      vy = vreg[y];
      npc = pc;
      want = '0;
      case (op)
        OpSys: begin
          if (nnn == SysCls) begin
            want.clear_screen = 1'b1;
          end else if (nnn == SysRet) begin
            sp = (sp == '0) ? SpLast : sp - 1'b1;
            npc = ret_stack[sp];
          end else begin
            want.unsupported = 1'b1;
          end
        end
        OpJump: npc = nnn;
        OpCall: begin
          ret_stack[sp] = pc;
          stack_written[sp] = 1'b1;
          sp = (sp == SpLast) ? '0 : sp + 1'b1;
          npc = nnn;
        end
        OpSeImm: if (vx == kk) npc = pc + 12'd2;
        OpSnImm: if (vx != kk) npc = pc + 12'd2;
        OpSeReg: if (vx == vy) npc = pc + 12'd2;
        OpLdImm: begin
          want.reg_written = 1'b1;
          want.reg_value = kk;
        end
        OpAdImm: begin
          want.reg_written = 1'b1;
          want.reg_value = vx + kk;
        end
        OpAlu: begin
          want.reg_written = 1'b1;
          case (n)
            AluMov: want.reg_value = vy;
            AluOr:  want.reg_value = vx | vy;
            AluAnd: want.reg_value = vx & vy;
            AluXor: want.reg_value = vx ^ vy;
            AluAdd: begin
              wide = {1'b0, vx} + {1'b0, vy};
              want.reg_value = wide[7:0];
              want.flag_written = 1'b1;
              want.flag_value = wide[8];
            end
            AluSub: begin
              want.reg_value = vx - vy;
              want.flag_written = 1'b1;
              want.flag_value = (vx >= vy);
            end
            AluShr: begin
              want.reg_value = vx >> 1;
              want.flag_written = 1'b1;
              want.flag_value = vx[0];
            end
            default: begin
              want.reg_written = 1'b0;
              want.unsupported = 1'b1;
            end
          endcase
        end
        default: want.unsupported = 1'b1;
      endcase
      pc = npc;
      want.next_pc = npc;
      if (want.reg_written) begin
        want.reg_index = x;
        vreg[x] = want.reg_value;
      end
      // The flag lands after the destination, so it wins when both are register 15.
      if (want.flag_written) vreg[RegFlag] = {7'd0, want.flag_value};
      pending_results.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result item with nothing pending: got %s", describe(got));
        end
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.next_pc !== want.next_pc || got.reg_written !== want.reg_written ||
          got.reg_index !== want.reg_index || got.reg_value !== want.reg_value ||
          got.flag_written !== want.flag_written || got.flag_value !== want.flag_value ||
          got.clear_screen !== want.clear_screen || got.unsupported !== want.unsupported) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result item %0d mismatch", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

[test/tb_top.sv]
// Top-level testbench driving instruction items into the CHIP-8 execute block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import c8ie_pkg::*;
  import c8ie_exec_tracker_pkg::*;

  localparam int unsigned RandomItems = 850;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned LongHoldAt  = 300;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainAt     = 600;
  localparam int unsigned CallBurstAt = 200;
  localparam int unsigned CallBurst   = 18;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm_sender = 1'b0;

  chip8_exec_tracker tracker = new();

  c8ie_ins_if ins_ch();
  c8ie_res_if res_ch();

  chip8_instruction_execute u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ins_i  (ins_ch),
    .res_o  (res_ch)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] random_word();
    logic [3:0]  x, y;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [15:0] w;
    int unsigned r;
    bit          hit;
    x = 4'($urandom);
    y = 4'($urandom);
    kk = 8'($urandom);
    nnn = 12'($urandom);
    hit = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 26) return {OpLdImm, x, kk};
    if (r < 34) return {OpAdImm, x, kk};
    if (r < 60) return {OpAlu, x, y, 4'($urandom_range(6))};
    if (r < 64) return {OpAlu, x, y, 4'($urandom_range(15, 7))};
    if (r < 67) return {OpSeImm, x, hit ? tracker.vreg[x] : kk};
    if (r < 70) return {OpSnImm, x, hit ? tracker.vreg[x] : kk};
    if (r < 73) return {OpSeReg, x, hit ? x : y, 4'($urandom)};
    if (r < 76) return {OpJump, nnn};
    if (r < 82) return {OpCall, nnn};
    if (r < 88) return tracker.can_return() ? {OpSys, SysRet} : {OpCall, nnn};
    if (r < 90) return {OpSys, SysCls};
    w = (r < 93) ? {OpSys, nnn} : 16'($urandom);
    if (w == {OpSys, SysRet} && !tracker.can_return()) w = {OpSys, SysCls};
    return w;
  endfunction

  task automatic send_instruction(input logic [15:0] word);
    int unsigned gap;
    gap = calm_sender ? 0 : idle_gap();
    if (gap > 0) begin
      ins_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ins_ch.valid <= 1'b1;
    ins_ch.instruction <= word;
    do @(posedge clk_i); while (!ins_ch.ready);
    tracker.note_instruction(word);
  endtask

  task automatic wait_results_drained();
    ins_ch.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  initial begin : stimulus
    ins_ch.valid <= 1'b0;
    ins_ch.instruction <= 16'h0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_instruction({OpLdImm, 4'h0, 8'h00});
    send_instruction({OpLdImm, RegFlag, 8'hFF});
    send_instruction({OpLdImm, 4'h1, 8'hFF});
    send_instruction({OpLdImm, 4'h2, 8'h01});
    send_instruction({OpAlu, 4'h1, 4'h2, AluAdd});
    send_instruction({OpAlu, RegFlag, 4'h2, AluAdd});
    send_instruction({OpAlu, 4'h0, 4'h2, AluSub});
    send_instruction({OpAlu, 4'h2, 4'h2, AluSub});
    send_instruction({OpAlu, 4'h0, 4'h0, AluShr});
    send_instruction({OpAlu, 4'h0, 4'h1, AluMov});
    send_instruction({OpAlu, 4'h0, RegFlag, AluOr});
    send_instruction({OpAlu, 4'h0, 4'h2, AluAnd});
    send_instruction({OpAlu, 4'h0, RegFlag, AluXor});
    send_instruction({OpAdImm, 4'h0, 8'hFF});
    send_instruction({OpSeImm, 4'h0, 8'hFF});
    send_instruction({OpSnImm, 4'h0, 8'h00});
    send_instruction({OpSeReg, 4'h0, 4'h0, 4'h1});
    send_instruction({OpSys, SysCls});
    send_instruction({OpCall, 12'hFFF});
    send_instruction({OpSys, SysRet});
    send_instruction({OpJump, 12'hFFE});
    send_instruction({OpSeReg, 4'h1, 4'h1, 4'h0});
    send_instruction({OpSys, 12'h123});
    send_instruction({OpAlu, 4'h0, 4'h1, 4'h7});
    send_instruction({OpAlu, 4'h0, 4'h1, 4'hF});
    send_instruction(16'h9000);
    send_instruction(16'hF0FF);

    for (int i = 0; i < RandomItems; i++) begin
      calm_sender = ((i / 100) % 4) == 2;
      // Nest deeper than the stack so it wraps, then unwind through every entry.
      if (i == CallBurstAt) begin
        repeat (CallBurst) send_instruction({OpCall, 12'($urandom)});
        repeat (CallBurst) send_instruction({OpSys, SysRet});
      end
      if (i == DrainAt) wait_results_drained();
      send_instruction(random_word());
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("chip8_instruction_execute test passed");
    end else begin
      $display("chip8_instruction_execute test failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned seen;
    bit          held_once;
    bit          calm;
    logic        ready_next;
    res_t        got;
    stall_left = 0;
    seen = 0;
    held_once = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.next_pc, res_ch.reg_written, res_ch.reg_index, res_ch.reg_value,
               res_ch.flag_written, res_ch.flag_value, res_ch.clear_screen,
               res_ch.unsupported};
        tracker.check_result(got);
        seen++;
        if (seen == LongHoldAt && !held_once) begin
          held_once = 1'b1;
          stall_left = LongHold;
        end
      end
      calm = ((seen / 120) % 3) == 1;
      if (stall_left == 0 && !calm && $urandom_range(3) == 0) stall_left = idle_gap();
      if (stall_left > 0) begin
        ready_next = 1'b0;
        stall_left--;
      end else begin
        ready_next = 1'b1;
      end
      res_ch.ready <= ready_next;
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((ins_ch.valid && ins_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("chip8_instruction_execute test failed");
    $finish;
  end

endmodule
